FILE: rtl/life_generation_engine_macros.svh
// Assertion macros used by the checker file of the life generation engine.
`ifndef LIFE_GENERATION_ENGINE_MACROS_SVH
`define LIFE_GENERATION_ENGINE_MACROS_SVH

// Implication to the next cycle, switched off while reset is asserted.
`define LGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("life generation engine: assertion failed");

// Implication to the next cycle that is checked during reset as well.
`define LGE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("life generation engine: assertion failed");

`endif

FILE: rtl/lge_pkg.sv
// Package with the types, codes and cell rule of the life generation engine.
`default_nettype none

package lge_pkg;

    // Command codes carried in the slave-side tuser.
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_TOGGLE = 2'd1;
    localparam logic [1:0] OP_STEP   = 2'd2;

    // Port widths.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    // Neighbour counts that matter for the B3/S23 rule.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_FILL,
        ST_RUN,
        ST_RESP
    } t_state;

    // A cell is live in the next generation when it has three live neighbours,
    // or when it is live now and has two.
    function automatic logic cell_rule(input logic live, input logic [3:0] count);
        cell_rule = (count == BIRTH_COUNT) || (live && (count == SURVIVE_COUNT));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lge_next_row.sv
// Next-generation logic for one row, from the old rows above, at and below it.
`default_nettype none

module lge_next_row #(
    parameter int COLS = 64
) (
    input  wire logic [COLS-1:0] i_above,
    input  wire logic [COLS-1:0] i_mid,
    input  wire logic [COLS-1:0] i_below,
    output logic      [COLS-1:0] o_next
);
    import lge_pkg::*;

    // Each row padded with a dead cell at either end, so that column c of the
    // grid sits at bit c+1 and cells beyond the edge count as dead.
    logic [COLS+1:0] pad_above;
    logic [COLS+1:0] pad_mid;
    logic [COLS+1:0] pad_below;

    assign pad_above = {1'b0, i_above, 1'b0};
    assign pad_mid   = {1'b0, i_mid,   1'b0};
    assign pad_below = {1'b0, i_below, 1'b0};

    for (genvar c = 0; c < COLS; c++) begin : g_cell
        logic [3:0] count;

        assign count = 4'(pad_above[c]) + 4'(pad_above[c+1]) + 4'(pad_above[c+2])
                     + 4'(pad_mid[c])                        + 4'(pad_mid[c+2])
                     + 4'(pad_below[c]) + 4'(pad_below[c+1]) + 4'(pad_below[c+2]);

        assign o_next[c] = cell_rule(i_mid[c], count);
    end

endmodule

`default_nettype wire

FILE: rtl/life_generation_engine.sv
// Top level of the life generation engine: row memory, command sequencer and output register.
//
//  Channel   Direction  Ports                        Contents of one beat
//  --------  ---------  ---------------------------  ----------------------------------------
//  command   in         i_s_tvalid/o_s_tready/...    tuser: opcode; tdata: row, col
//  result    out        o_m_tvalid/i_m_tready/...    tdata: cell_alive
//
// A read or toggle passes through the memory read, the update, and the load of the output
// register before the next command can be accepted.
// A step sweeps the grid one row per cycle through the single read and single write port of
// the row memory, after a fill of two rows into the window registers.
// After reset the engine writes the starting pattern into every row of the memory, one row
// per cycle, and accepts no command until that pass is over.
// A result that is not taken waits in the output register; the next command is still accepted
// and worked on, but its result holds the engine until the earlier one is taken.
`default_nettype none

module life_generation_engine #(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // Bits 5:0 row, bits 11:6 col, bits 15:12 zero.
    input  wire logic [lge_pkg::S_TDATA_W-1:0] i_s_tdata,
    // Bits 1:0 opcode.
    input  wire logic [lge_pkg::S_TUSER_W-1:0] i_s_tuser,

    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // Bit 0 cell_alive, bits 7:1 zero.
    output logic      [lge_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import lge_pkg::*;

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam logic [RW-1:0] LAST_ROW = RW'(GRID_ROWS - 1);
    localparam logic [RW:0]   ROW_LIMIT = (RW + 1)'(GRID_ROWS);
    // Odd-numbered columns live, even ones dead.
    localparam logic [GRID_COLS-1:0] START_PATTERN = GRID_COLS'({(GRID_COLS / 2 + 1){2'b10}});

    // Command fields as they arrive.
    logic [1:0] in_opcode;
    logic [5:0] in_row;
    logic [5:0] in_col;

    assign in_opcode = i_s_tuser[1:0];
    assign in_row    = i_s_tdata[5:0];
    assign in_col    = i_s_tdata[11:6];

    t_state r_state;
    t_state n_state;

    logic [RW-1:0]        r_ptr;      // Row being cleared or written by a step.
    logic [1:0]           r_op;
    logic [RW-1:0]        r_row;
    logic [CW-1:0]        r_col;
    logic                 r_hit;      // Read or toggle that falls inside the grid.
    logic                 r_res;
    logic                 r_out_valid;
    logic                 r_out_data;
    logic [GRID_COLS-1:0] r_above;    // Old row above the one being computed.
    logic [GRID_COLS-1:0] r_mid;      // Old row being computed.
    logic [GRID_COLS-1:0] r_rd_data;

    // The grid: bit c of entry r is the cell at row r, column c.
    logic [GRID_COLS-1:0] mem [GRID_ROWS];

    logic                 s_accept;
    logic                 out_free;
    logic                 rd_en;
    logic [RW-1:0]        rd_addr;
    logic                 wr_en;
    logic [RW-1:0]        wr_addr;
    logic [GRID_COLS-1:0] wr_data;
    logic [GRID_COLS-1:0] below;
    logic [GRID_COLS-1:0] next_row;
    logic [GRID_COLS-1:0] toggled;
    logic [RW:0]          ahead;
    logic                 in_hit;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // Reads and toggles address the grid only when both indices lie inside it.
    assign in_hit = ((in_opcode == OP_READ) || (in_opcode == OP_TOGGLE))
                 && (32'(in_row) < GRID_ROWS) && (32'(in_col) < GRID_COLS);

    // The row below the last one is outside the grid and counts as dead.
    assign below = (r_ptr == LAST_ROW) ? '0 : r_rd_data;
    assign ahead = {1'b0, r_ptr} + (RW + 1)'(2);

    always_comb begin
        toggled        = r_rd_data;
        toggled[r_col] = ~r_rd_data[r_col];
    end

    lge_next_row #(
        .COLS (GRID_COLS)
    ) u_next_row (
        .i_above (r_above),
        .i_mid   (r_mid),
        .i_below (below),
        .o_next  (next_row)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_ptr == LAST_ROW) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = (in_opcode == OP_STEP) ? ST_FILL : ST_CELL;
                end
            end
            ST_CELL: begin
                n_state = ST_RESP;
            end
            ST_FILL: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_ptr == LAST_ROW) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Memory port control.
    always_comb begin
        o_s_tready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = r_ptr;
        wr_data    = next_row;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = START_PATTERN;
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (s_accept) begin
                    rd_en   = 1'b1;
                    rd_addr = (in_opcode == OP_STEP) ? '0 : RW'(in_row);
                end
            end
            ST_CELL: begin
                if (r_hit && (r_op == OP_TOGGLE)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_row;
                    wr_data = toggled;
                end
            end
            ST_FILL: begin
                rd_en   = 1'b1;
                rd_addr = RW'(1);
            end
            ST_RUN: begin
                // Row r is written while row r+2 is fetched; row r+1 is already held,
                // so no row is read after it has been overwritten.
                wr_en = 1'b1;
                if (ahead < ROW_LIMIT) begin
                    rd_en   = 1'b1;
                    rd_addr = ahead[RW-1:0];
                end
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // Row memory with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_CLEAR) || (r_state == ST_RUN)) begin
                r_ptr <= (r_ptr == LAST_ROW) ? '0 : r_ptr + RW'(1);
            end
            if ((r_state == ST_RESP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op  <= in_opcode;
            r_row <= RW'(in_row);
            r_col <= CW'(in_col);
            r_hit <= in_hit;
            r_res <= 1'b0;
        end
        if (r_state == ST_CELL) begin
            r_res <= r_hit && (r_rd_data[r_col] ^ (r_op == OP_TOGGLE));
        end
        if ((r_state == ST_RESP) && out_free) begin
            r_out_data <= r_res;
        end
        if (r_state == ST_FILL) begin
            r_above <= '0;
            r_mid   <= r_rd_data;
        end else if (r_state == ST_RUN) begin
            r_above <= r_mid;
            r_mid   <= below;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - 1)'(0), r_out_data};

endmodule

`default_nettype wire

FILE: rtl/lge_checker.sv
// Port checker of the life generation engine and its bind to the top level.
`default_nettype none

`include "life_generation_engine_macros.svh"

module lge_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic [lge_pkg::S_TDATA_W-1:0] i_s_tdata,
    input wire logic [lge_pkg::S_TUSER_W-1:0] i_s_tuser,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [lge_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import lge_pkg::*;

    logic s_accept;
    logic m_stall;
    logic any_seen;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign m_stall  = o_m_tvalid && !i_m_tready;
    // Keeps every input in use for the checker.
    assign any_seen = ^{i_s_tdata, i_s_tuser};

    // A result beat that is held back stays offered and unchanged.
    `LGE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_stall, o_m_tvalid)
    `LGE_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_stall, $stable(o_m_tdata))

    // Commands are worked on one at a time: the engine is busy after taking one.
    `LGE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_accept || (any_seen && s_accept),
                     !o_s_tready)

    // Reset empties the output register and starts the clearing pass.
    `LGE_ASSERT_NEXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !o_m_tvalid && !o_s_tready)

endmodule

bind life_generation_engine lge_checker u_lge_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
